@@ rtl/rtu_pkg.sv @@
// ----------------------------------------------------------------------------
// RTU frame check package
// Shared types, status codes and the byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package rtu_pkg;

  localparam int          MIN_FRAME_LEN = 5;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  // Result queue geometry.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [7:0]  station_id;
    logic [7:0]  function_code;
    logic [15:0] received_crc;
    logic        last;
  } result_t;

  // Results produced by one frame byte: an optional payload result followed
  // by an optional status result.
  typedef struct packed {
    logic    payload_v;
    logic    status_v;
    result_t payload;
    result_t status_res;
  } push_t;

  // One byte through the reflected CRC, eight shift steps unrolled.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/rtu_if.sv @@
// ----------------------------------------------------------------------------
// RTU frame check channels
// Valid/ready channels for received frame bytes and for results.
// ----------------------------------------------------------------------------
interface rtu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface rtu_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [1:0]  status;
  logic [7:0]  station_id;
  logic [7:0]  function_code;
  logic [15:0] received_crc;
  logic        last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output station_id, output function_code, output received_crc,
                  output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input station_id, input function_code, input received_crc,
                  input last, output ready);
endinterface

@@ rtl/rtu_frame_core.sv @@
// ----------------------------------------------------------------------------
// RTU frame core
// Frame state, two-byte hold window and running CRC; builds the results of
// one byte in a single pass.
// ----------------------------------------------------------------------------
module rtu_frame_core import rtu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       eof_in,
  output push_t      push
);

  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [7:0]  older_r, older_nxt;
  logic [7:0]  newer_r, newer_nxt;
  logic [7:0]  station_r, station_nxt;
  logic [7:0]  function_r, function_nxt;

  logic [15:0] crc_adv;
  logic [15:0] rx_crc;
  logic [3:0]  total;
  logic        too_short;

  always_comb begin
    crc_adv      = (count_r >= 3'd2) ? crc_byte(crc_r, older_r) : crc_r;
    total        = {1'b0, count_r} + 4'd1;
    too_short    = total < 4'(MIN_FRAME_LEN);
    station_nxt  = (count_r == 3'd0) ? byte_in : station_r;
    function_nxt = (count_r == 3'd1) ? byte_in : function_r;
    // The two newest bytes, low byte first, once this byte is in the window.
    rx_crc       = {byte_in, newer_r};

    push.payload_v                = step && (count_r >= 3'd4);
    push.payload.kind             = KIND_PAYLOAD;
    push.payload.payload_byte     = older_r;
    push.payload.status           = STATUS_OK;
    push.payload.station_id       = 8'h00;
    push.payload.function_code    = 8'h00;
    push.payload.received_crc     = 16'h0000;
    push.payload.last             = !eof_in;

    push.status_v                 = step && eof_in;
    push.status_res.kind          = KIND_STATUS;
    push.status_res.payload_byte  = 8'h00;
    push.status_res.station_id    = station_nxt;
    push.status_res.function_code = function_nxt;
    push.status_res.last          = 1'b1;
    if (too_short) begin
      push.status_res.status       = STATUS_SHORT;
      push.status_res.received_crc = 16'h0000;
    end else begin
      push.status_res.status       = (crc_adv == rx_crc) ? STATUS_OK : STATUS_MISMATCH;
      push.status_res.received_crc = rx_crc;
    end

    // End of frame returns everything to the reset state.
    if (eof_in) begin
      crc_nxt      = CRC_INIT;
      count_nxt    = 3'd0;
      older_nxt    = 8'h00;
      newer_nxt    = 8'h00;
    end else begin
      crc_nxt      = crc_adv;
      count_nxt    = (count_r == 3'd7) ? 3'd7 : total[2:0];
      older_nxt    = newer_r;
      newer_nxt    = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      count_r    <= 3'd0;
      older_r    <= 8'h00;
      newer_r    <= 8'h00;
      station_r  <= 8'h00;
      function_r <= 8'h00;
    end else if (step) begin
      crc_r      <= crc_nxt;
      count_r    <= count_nxt;
      older_r    <= older_nxt;
      newer_r    <= newer_nxt;
      station_r  <= eof_in ? 8'h00 : station_nxt;
      function_r <= eof_in ? 8'h00 : function_nxt;
    end
  end

  // A frame end always leaves an empty frame state behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    step && eof_in |=> count_r == 3'd0 && crc_r == CRC_INIT)
    else $error("frame state not cleared after end of frame");

  // A short frame never reports a CRC value and never yields a payload result.
  assert property (@(posedge clk) disable iff (!rst_n)
    push.status_v && push.status_res.status == STATUS_SHORT |->
      push.status_res.received_crc == 16'h0000 && !push.payload_v)
    else $error("short frame reported CRC or payload");

endmodule

@@ rtl/rtu_result_fifo.sv @@
// ----------------------------------------------------------------------------
// RTU result queue
// Small register queue that takes up to two results a cycle and hands out
// one result a cycle.
// ----------------------------------------------------------------------------
module rtu_result_fifo import rtu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output logic    room,
  output logic    head_v,
  output result_t head
);

  result_t                entry_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]   count_r, count_nxt;
  logic [RES_PTR_W-1:0]   status_ptr;
  logic                   pop_ok;

  always_comb begin
    pop_ok     = pop && (count_r != '0);
    status_ptr = wr_ptr_r + RES_PTR_W'(push.payload_v);
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.payload_v) + RES_PTR_W'(push.status_v);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop_ok);
    count_nxt  = count_r + RES_CNT_W'(push.payload_v) + RES_CNT_W'(push.status_v)
               - RES_CNT_W'(pop_ok);
    // Room for the worst case of two results from one byte.
    room       = count_r <= RES_CNT_W'(RES_DEPTH - 2);
    head_v     = count_r != '0;
    head       = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.payload_v) begin
      entry_r[wr_ptr_r] <= push.payload;
    end
    if (push.status_v) begin
      entry_r[status_ptr] <= push.status_res;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (push.payload_v || push.status_v) |-> room)
    else $error("result pushed without room");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

endmodule

@@ rtl/rtu_frame_crc_check.sv @@
// ----------------------------------------------------------------------------
// RTU frame CRC check
// Receives a Modbus RTU frame byte by byte, passes payload bytes and
// reports one status result per frame.
// ----------------------------------------------------------------------------
// Path: a byte is accepted into the input register, and its results are then
// written to the result queue, from which the first of them is offered.
// Throughput: one byte per cycle while the result queue has room; the final
// byte of a frame of five or more bytes yields two results, handed out in order.
// Reset: synchronous, active low; clears the frame state to an empty frame
// with the CRC at 0xFFFF and empties the input register and result queue.
module rtu_frame_crc_check import rtu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  rtu_in_if.sink   in_ch,
  rtu_out_if.source out_ch
);

  // Input register. A request is held here until the result queue has room
  // for both results that it may cause.
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_eof_r;

  logic       room;
  logic       step;
  logic       accept;
  push_t      push;
  logic       head_v;
  result_t    head;

  // The byte in the input register is processed whenever the queue can take
  // its results; the register refills in the same cycle, so bytes stream at
  // one per cycle while the output keeps up.
  assign step     = in_v_r && room;
  assign in_ch.ready = !in_v_r || step;
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_ch.data_byte;
      in_eof_r  <= in_ch.end_of_frame;
    end
  end

  // Frame state, hold window and CRC: all the work of one byte happens in
  // this single combinational pass.
  rtu_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .eof_in  (in_eof_r),
    .push    (push)
  );

  // Results are queued in order: payload first, then the frame status.
  rtu_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (out_ch.ready),
    .room   (room),
    .head_v (head_v),
    .head   (head)
  );

  assign out_ch.valid         = head_v;
  assign out_ch.kind          = head.kind;
  assign out_ch.payload_byte  = head.payload_byte;
  assign out_ch.status        = head.status;
  assign out_ch.station_id    = head.station_id;
  assign out_ch.function_code = head.function_code;
  assign out_ch.received_crc  = head.received_crc;
  assign out_ch.last          = head.last;

  // A byte waiting for queue room stays put in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r && $stable(in_byte_r) && $stable(in_eof_r))
    else $error("stalled input byte lost");

endmodule
